// File: rtl/key_index_to_candidate_core_macros.svh
// Assertion helpers used by the candidate generator back end.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef KEY_INDEX_TO_CANDIDATE_CORE_MACROS_SVH
`define KEY_INDEX_TO_CANDIDATE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define KITC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kitc assertion failed");
// Expression must never be true outside reset.
`define KITC_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("kitc forbidden condition seen");
`else
`define KITC_ASSERT(name, prop)
`define KITC_NEVER(name, expr)
`endif
`endif

// File: rtl/kitc_pkg.sv
package kitc_pkg;

  // Sizes of the alphabet store and of a candidate
  localparam int unsigned ALPHABET_DEPTH = 64;
  localparam int unsigned MAX_KEY_LEN    = 16;

  // Field widths
  localparam int unsigned KEY_W    = 63;
  localparam int unsigned SLOT_W   = $clog2(ALPHABET_DEPTH);
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = $clog2(MAX_KEY_LEN);
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned ALEN_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = ALEN_W;

  // Arithmetic widths: powers are held saturated at 2^KEY_W
  localparam int unsigned POW_W   = KEY_W + 1;
  localparam int unsigned ACC_W   = POW_W + ALEN_W - 1;
  localparam int unsigned DIGIT_W = ALEN_W;
  localparam int unsigned BIT_W   = $clog2(ALEN_W);

  // Queue depth on both sides of the sequencer
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_GEN  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHABET_LENGTH = 2'd0,
    CFG_MIN_LENGTH      = 2'd1,
    CFG_MAX_LENGTH      = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_EMIT,
    S_OOR
  } back_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [KEY_W-1:0]  key_index;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] sym;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  char_position;
    logic [BYTE_W-1:0] char_code;
    logic [LEN_W-1:0]  key_length;
    logic              out_of_range;
    logic              last_char;
  } result_t;

  // Effective bounds after clamping
  typedef struct packed {
    logic [ALEN_W-1:0] radix;
    logic [LEN_W-1:0]  lo;
    logic [LEN_W-1:0]  hi;
  } cfg_t;

endpackage

// File: rtl/kitc_ram.sv
module kitc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/kitc_front.sv
module kitc_front import kitc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              opcode_i,
  input  logic [KEY_W-1:0]  key_index_i,
  input  logic [SLOT_W-1:0] symbol_slot_i,
  input  logic [BYTE_W-1:0] symbol_byte_i,
  output logic              item_valid_o,
  output item_t             item_o,
  input  logic              item_take_i
);

  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               wr_ptr_q, rd_ptr_q;
  item_t              mem_q [Q_DEPTH];
  item_t              item_in;
  logic               push_ok;

  // Classify the incoming item
  always_comb begin
    item_in.kind      = opcode_i ? KIND_GEN : KIND_LOAD;
    item_in.key_index = key_index_i;
    item_in.slot      = symbol_slot_i;
    item_in.sym       = symbol_byte_i;
  end

  assign full         = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign push_ok      = push && !full;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_ok, item_take_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_ok) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_take_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// File: rtl/kitc_outq.sv
module kitc_outq import kitc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_push_i,
  input  result_t res_i,
  output logic    res_full_o,
  output logic    empty,
  input  logic    pop,
  output result_t res_o
);

  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               wr_ptr_q, rd_ptr_q;
  result_t            mem_q [Q_DEPTH];
  logic               pop_ok;

  assign res_full_o = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty      = (cnt_q == '0);
  assign pop_ok     = pop && !empty;
  assign res_o      = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({res_push_i, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (res_push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// File: rtl/kitc_back.sv
`include "key_index_to_candidate_core_macros.svh"

module kitc_back import kitc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_take_o,
  output logic    res_push_o,
  output result_t res_o,
  input  logic    res_full_i
);

  localparam logic [POW_W-1:0] POW_SAT = POW_W'(1) << KEY_W;
  localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(DIGIT_W - 1);

  back_state_e        st_q, st_d;
  logic [KEY_W-1:0]   n_q, n_d;
  logic [POW_W-1:0]   pow_q, pow_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   pidx_q, pidx_d;

  // Power table: radix^k for k below the candidate length
  logic [POW_W-1:0]   pow_arr_q [MAX_KEY_LEN];
  logic               pa_we;
  logic [POS_W-1:0]   pa_idx;
  logic [POW_W-1:0]   pa_data;

  logic [POW_W-1:0]   p_sat;
  logic               fits;
  logic [ACC_W-1:0]   ps;
  logic               ge;
  logic               last;

  logic               ram_we, ram_re;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  // Saturated power out of the multiply accumulator
  assign p_sat = (|acc_q[ACC_W-1:KEY_W]) ? POW_SAT : acc_q[POW_W-1:0];
  assign fits  = ({1'b0, n_q} < p_sat);

  // One restoring quotient bit against the stored power
  assign ps = ACC_W'(pow_arr_q[pidx_q]) << bit_q;
  assign ge = (ps <= ACC_W'(n_q));

  assign last = ((LEN_W'(pos_q) + 1'b1) == len_q);

  assign item_take_o = item_valid_i && (st_q == S_IDLE);
  assign ram_we      = item_take_o && (item_i.kind == KIND_LOAD);

  // Sequencer
  always_comb begin
    st_d       = st_q;
    n_d        = n_q;
    pow_d      = pow_q;
    acc_d      = acc_q;
    bit_d      = bit_q;
    len_d      = len_q;
    digit_d    = digit_q;
    pos_d      = pos_q;
    pidx_d     = pidx_q;
    pa_we      = 1'b0;
    pa_idx     = '0;
    pa_data    = POW_W'(1);
    ram_re     = 1'b0;
    ram_raddr  = digit_q[SLOT_W-1:0];
    res_push_o = 1'b0;
    res_o      = '0;
    case (st_q)
      S_IDLE: begin
        if (item_take_o && (item_i.kind == KIND_GEN)) begin
          if ((cfg_i.radix == '0) || (cfg_i.lo > cfg_i.hi)) begin
            st_d = S_OOR;
          end else begin
            n_d    = item_i.key_index;
            pow_d  = POW_W'(1);
            acc_d  = '0;
            bit_d  = BIT_TOP;
            len_d  = LEN_W'(1);
            pa_we  = 1'b1;
            st_d   = S_MUL;
          end
        end
      end
      S_MUL: begin
        acc_d = {acc_q[ACC_W-2:0], 1'b0} + (cfg_i.radix[bit_q] ? ACC_W'(pow_q) : '0);
        if (bit_q == '0) begin
          st_d = S_CHECK;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      S_CHECK: begin
        if (len_q < LEN_W'(MAX_KEY_LEN)) begin
          pa_we   = 1'b1;
          pa_idx  = len_q[POS_W-1:0];
          pa_data = p_sat;
        end
        if ((len_q >= cfg_i.lo) && fits) begin
          pidx_d  = POS_W'(len_q - 1'b1);
          pos_d   = '0;
          digit_d = '0;
          bit_d   = BIT_TOP;
          st_d    = S_DIV;
        end else begin
          if (len_q >= cfg_i.lo) begin
            n_d = n_q - p_sat[KEY_W-1:0];
          end
          if (len_q == cfg_i.hi) begin
            st_d = S_OOR;
          end else begin
            len_d = len_q + 1'b1;
            pow_d = p_sat;
            acc_d = '0;
            bit_d = BIT_TOP;
            st_d  = S_MUL;
          end
        end
      end
      S_DIV: begin
        digit_d = {digit_q[DIGIT_W-2:0], ge};
        if (ge) begin
          n_d = n_q - ps[KEY_W-1:0];
        end
        if (bit_q == '0) begin
          ram_re    = 1'b1;
          ram_raddr = digit_d[SLOT_W-1:0];
          st_d      = S_EMIT;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      S_EMIT: begin
        res_o.char_position = pos_q;
        res_o.char_code     = ram_rdata;
        res_o.key_length    = len_q;
        res_o.out_of_range  = 1'b0;
        res_o.last_char     = last;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (last) begin
            st_d = S_IDLE;
          end else begin
            pos_d   = pos_q + 1'b1;
            pidx_d  = pidx_q - 1'b1;
            digit_d = '0;
            bit_d   = BIT_TOP;
            st_d    = S_DIV;
          end
        end
      end
      S_OOR: begin
        res_o.out_of_range = 1'b1;
        res_o.last_char    = 1'b1;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          st_d       = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    pow_q   <= pow_d;
    acc_q   <= acc_d;
    bit_q   <= bit_d;
    len_q   <= len_d;
    digit_q <= digit_d;
    pos_q   <= pos_d;
    pidx_q  <= pidx_d;
    if (pa_we) begin
      pow_arr_q[pa_idx] <= pa_data;
    end
  end

  // Alphabet store
  kitc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ALPHABET_DEPTH)
  ) u_alpha (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_i.slot),
    .wdata_i (item_i.sym),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `KITC_ASSERT(a_walk_in_bounds, (st_q == S_CHECK) |-> ((len_q <= cfg_i.hi) && (len_q != '0)))
  `KITC_ASSERT(a_digit_below_radix, (st_q == S_EMIT) |-> (digit_q < cfg_i.radix))
  `KITC_ASSERT(a_oor_single, ((st_q == S_OOR) && !res_full_i) |=> (st_q == S_IDLE))
  `KITC_NEVER(a_no_push_when_full, res_push_o && res_full_i)

endmodule

// File: rtl/key_index_to_candidate_core.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------------
// item in   | input     | push / full            | opcode, key_index, symbol_slot/_byte
// result    | output    | empty / pop            | char_position, char_code, key_length, ...
// config    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A load writes the alphabet store while the sequencer is idle. A generate walks
// each length with 7 shift-add steps for radix^L plus a compare/subtract, then
// emits each character after 7 quotient steps, the last also reading the table.
// Two-entry queues sit on the input and result sides; the sequencer stalls only
// when the result queue is full. Reset needs no clearing pass; config resets to
// alphabet_length 1, min_length 1, max_length 8.
module key_index_to_candidate_core import kitc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic                 opcode_i,
  input  logic [KEY_W-1:0]     key_index_i,
  input  logic [SLOT_W-1:0]    symbol_slot_i,
  input  logic [BYTE_W-1:0]    symbol_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [POS_W-1:0]     char_position_o,
  output logic [BYTE_W-1:0]    char_code_o,
  output logic [LEN_W-1:0]     key_length_o,
  output logic                 out_of_range_o,
  output logic                 last_char_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  logic [ALEN_W-1:0] alen_q, alen_d;
  logic [LEN_W-1:0]  minl_q, minl_d;
  logic [LEN_W-1:0]  maxl_q, maxl_d;
  cfg_t              cfg;

  logic    item_valid, item_take;
  item_t   item;
  logic    res_push, res_full;
  result_t res_in, res_out;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped
  always_comb begin
    alen_d = alen_q;
    minl_d = minl_q;
    maxl_d = maxl_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ALPHABET_LENGTH: alen_d = cfg_data_i;
        CFG_MIN_LENGTH:      minl_d = cfg_data_i[LEN_W-1:0];
        CFG_MAX_LENGTH:      maxl_d = cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alen_q <= ALEN_W'(1);
      minl_q <= LEN_W'(1);
      maxl_q <= LEN_W'(8);
    end else begin
      alen_q <= alen_d;
      minl_q <= minl_d;
      maxl_q <= maxl_d;
    end
  end

  // Clamp the bounds once for the sequencer
  always_comb begin
    cfg.radix = (alen_q > ALEN_W'(ALPHABET_DEPTH)) ? ALEN_W'(ALPHABET_DEPTH) : alen_q;
    cfg.lo    = (minl_q == '0) ? LEN_W'(1) : minl_q;
    cfg.hi    = (maxl_q > LEN_W'(MAX_KEY_LEN)) ? LEN_W'(MAX_KEY_LEN) : maxl_q;
  end

  kitc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .key_index_i   (key_index_i),
    .symbol_slot_i (symbol_slot_i),
    .symbol_byte_i (symbol_byte_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_take_i   (item_take)
  );

  kitc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  kitc_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  assign char_position_o = res_out.char_position;
  assign char_code_o     = res_out.char_code;
  assign key_length_o    = res_out.key_length;
  assign out_of_range_o  = res_out.out_of_range;
  assign last_char_o     = res_out.last_char;

endmodule
